@@ hdl/msarm_pkg.sv @@
// Shared types and constants for the multi-source audio ring mixer.
`timescale 1ns / 1ps
`default_nettype none
package msarm_pkg;

    typedef enum logic [2:0] {
        FUNC_WRITE  = 3'd0,
        FUNC_MIX    = 3'd1,
        FUNC_PLAY   = 3'd2,
        FUNC_PAUSE  = 3'd3,
        FUNC_STOP   = 3'd4,
        FUNC_VOLUME = 3'd5,
        FUNC_OPEN   = 3'd6,
        FUNC_CLOSE  = 3'd7
    } t_func;

    typedef enum logic [1:0] {
        MODE_STOPPED = 2'd0,
        MODE_PLAYING = 2'd1,
        MODE_PAUSED  = 2'd2
    } t_mode;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_INACTIVE = 2'd1,
        ST_FULL     = 2'd2
    } t_status;

    localparam logic [6:0]  FULL_SCALE   = 7'd100;
    localparam logic [6:0]  MASTER_RESET = 7'd80;
    localparam int          ABS_W        = 28;
    localparam int          REC_W        = 56;
    localparam int          RECIP_SH     = 34;
    localparam logic [27:0] RECIP_M      = 28'd171798692;
    localparam int          QUO_W        = REC_W - RECIP_SH;
    localparam logic signed [QUO_W:0] SAT_HI = (QUO_W+1)'(32767);
    localparam logic signed [QUO_W:0] SAT_LO = -(QUO_W+1)'(32768);

endpackage
`default_nettype wire

@@ hdl/multi_source_audio_ring_mixer.sv @@
// Top level of the multi-source audio ring mixer: sequencer, source state and sample store.
// Control operations pass through S_OP to S_OUT after the input transfer, and their result is registered.
// A mix tick steps through S_RD, S_MUL, S_REC and S_ACC for each source, then S_MMUL, S_REC,
// S_MFIN and S_OUT, set by the one-port sample store read and two registered multiplies per source.
// One item is in work at a time; the next is taken while a result still waits.
// Synchronous active-low reset closes all sources, sets volumes to 100, master to 80.
`timescale 1ns / 1ps
`default_nettype none
module multi_source_audio_ring_mixer #(
    parameter int NUM_SOURCES  = 8,
    parameter int RING_SAMPLES = 1024
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [6:0]  i_cfg_data,     // master gain in percent
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [23:0] s_axis_tdata,   // sample_value[15:0], gain_request[22:16]
    input  wire logic [5:0]  s_axis_tuser,   // func[2:0], source_sel[5:3]
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [71:0]      m_axis_tdata,   // mixed_sample[15:0], source_index[18:16],
                                             // free_samples[29:19], played_samples[61:30],
                                             // current_volume[68:62], source_active[69]
    output logic [1:0]       m_axis_tuser    // status[1:0]
);

    localparam int SEL_W  = (NUM_SOURCES > 1) ? $clog2(NUM_SOURCES) : 1;
    localparam int PTR_W  = $clog2(RING_SAMPLES);
    localparam int CNT_W  = $clog2(RING_SAMPLES + 1);
    localparam int DEPTH  = NUM_SOURCES * RING_SAMPLES;
    localparam int AW     = $clog2(DEPTH);
    localparam int SUM_W  = 18 + $clog2(NUM_SOURCES);
    localparam int PROD_W = SUM_W + 8;
    localparam int QW     = msarm_pkg::QUO_W;

    typedef enum logic [9:0] {
        S_IDLE = 10'b0000000001,
        S_OP   = 10'b0000000010,
        S_RD   = 10'b0000000100,
        S_MUL  = 10'b0000001000,
        S_REC  = 10'b0000010000,
        S_ACC  = 10'b0000100000,
        S_MMUL = 10'b0001000000,
        S_MFIN = 10'b0010000000,
        S_OUT  = 10'b0100000000,
        S_SPARE = 10'b1000000000
    } t_state;

    t_state r_state;

    logic [15:0]             r_mem [DEPTH];
    logic [15:0]             r_mem_q;

    logic [PTR_W-1:0]        r_wptr   [NUM_SOURCES];
    logic [PTR_W-1:0]        r_rptr   [NUM_SOURCES];
    logic [CNT_W-1:0]        r_fill   [NUM_SOURCES];
    logic [31:0]             r_played [NUM_SOURCES];
    logic [6:0]              r_gain   [NUM_SOURCES];
    msarm_pkg::t_mode        r_mode   [NUM_SOURCES];
    logic [NUM_SOURCES-1:0]  r_open;

    logic [6:0]              r_master;
    msarm_pkg::t_func        r_func;
    logic [2:0]              r_sel;
    logic [SEL_W-1:0]        r_idx;
    logic [15:0]             r_sample;
    logic [6:0]              r_greq;
    logic                    r_blank;
    msarm_pkg::t_status      r_status;
    logic                    r_elig;
    logic                    r_mphase;
    logic                    r_neg;
    logic signed [PROD_W-1:0] r_prod;
    logic [msarm_pkg::REC_W-1:0] r_rec;
    logic signed [SUM_W-1:0] r_sum;
    logic [15:0]             r_mix;
    logic                    r_m_valid;
    logic [71:0]             r_m_data;
    logic [1:0]              r_m_user;

    msarm_pkg::t_func        in_func;
    logic [2:0]              in_sel;
    logic                    free_found;
    logic [SEL_W-1:0]        free_idx;
    logic [AW-1:0]           rd_addr;
    logic [AW-1:0]           wr_addr;
    logic                    wr_en;
    logic [PROD_W-1:0]       prod_abs;
    logic [QW-1:0]           quo;
    logic signed [QW:0]      quo_s;
    logic [16:0]             free17;
    logic                    last_src;

    assign in_func = msarm_pkg::t_func'(s_axis_tuser[2:0]);
    assign in_sel  = s_axis_tuser[5:3];

    always_comb begin
        free_found = 1'b0;
        free_idx   = '0;
        for (int s = NUM_SOURCES - 1; s >= 0; s--) begin
            if (!r_open[s]) begin
                free_found = 1'b1;
                free_idx   = SEL_W'(s);
            end
        end
    end

    assign rd_addr  = AW'(r_idx * RING_SAMPLES) + AW'(r_rptr[r_idx]);
    assign wr_addr  = AW'(r_idx * RING_SAMPLES) + AW'(r_wptr[r_idx]);
    assign wr_en    = (r_state == S_OP) && (r_func == msarm_pkg::FUNC_WRITE) && !r_blank
                      && r_open[r_idx] && (r_fill[r_idx] < CNT_W'(RING_SAMPLES));
    assign prod_abs = r_prod[PROD_W-1] ? -r_prod : r_prod;
    assign quo      = r_rec[msarm_pkg::REC_W-1:msarm_pkg::RECIP_SH];
    assign quo_s    = r_neg ? -$signed({1'b0, quo}) : $signed({1'b0, quo});
    assign free17   = 17'(RING_SAMPLES) - 17'(r_fill[r_idx]);
    assign last_src = (r_idx == SEL_W'(NUM_SOURCES - 1));

    assign o_cfg_ready   = 1'b1;
    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = r_m_data;
    assign m_axis_tuser  = r_m_user;

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= r_sample;
        end
        r_mem_q <= r_mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_master  <= msarm_pkg::MASTER_RESET;
            r_open    <= '0;
            r_m_valid <= 1'b0;
            for (int s = 0; s < NUM_SOURCES; s++) begin
                r_wptr[s]   <= '0;
                r_rptr[s]   <= '0;
                r_fill[s]   <= '0;
                r_played[s] <= '0;
                r_gain[s]   <= msarm_pkg::FULL_SCALE;
                r_mode[s]   <= msarm_pkg::MODE_STOPPED;
            end
        end else begin
            if (i_cfg_valid) begin
                r_master <= (i_cfg_data > msarm_pkg::FULL_SCALE) ?
                            msarm_pkg::FULL_SCALE : i_cfg_data;
            end
            if (m_axis_tready && (r_state != S_OUT)) begin
                r_m_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (s_axis_tvalid) begin
                        r_func   <= in_func;
                        r_sel    <= in_sel;
                        r_sample <= s_axis_tdata[15:0];
                        r_greq   <= s_axis_tdata[22:16];
                        r_status <= msarm_pkg::ST_OK;
                        r_sum    <= '0;
                        r_mphase <= 1'b0;
                        if (in_func == msarm_pkg::FUNC_MIX) begin
                            r_idx   <= '0;
                            r_blank <= 1'b1;
                            r_state <= S_RD;
                        end else if (in_func == msarm_pkg::FUNC_OPEN) begin
                            r_idx   <= free_idx;
                            r_blank <= !free_found;
                            r_state <= S_OP;
                        end else begin
                            r_idx   <= SEL_W'(in_sel);
                            r_blank <= (32'(in_sel) >= NUM_SOURCES);
                            r_state <= S_OP;
                        end
                    end
                end
                S_OP: begin
                    r_state <= S_OUT;
                    if (r_blank) begin
                        r_status <= msarm_pkg::ST_INACTIVE;
                    end else begin
                        case (r_func)
                            msarm_pkg::FUNC_WRITE: begin
                                if (!r_open[r_idx]) begin
                                    r_status <= msarm_pkg::ST_INACTIVE;
                                end else if (!wr_en) begin
                                    r_status <= msarm_pkg::ST_FULL;
                                end else begin
                                    r_wptr[r_idx] <= (r_wptr[r_idx] == PTR_W'(RING_SAMPLES - 1))
                                                     ? '0 : r_wptr[r_idx] + 1'b1;
                                    r_fill[r_idx] <= r_fill[r_idx] + 1'b1;
                                end
                            end
                            msarm_pkg::FUNC_PLAY: r_mode[r_idx] <= msarm_pkg::MODE_PLAYING;
                            msarm_pkg::FUNC_PAUSE: r_mode[r_idx] <= msarm_pkg::MODE_PAUSED;
                            msarm_pkg::FUNC_VOLUME: begin
                                r_gain[r_idx] <= (r_greq > msarm_pkg::FULL_SCALE) ?
                                                 msarm_pkg::FULL_SCALE : r_greq;
                            end
                            default: begin
                                r_mode[r_idx]   <= msarm_pkg::MODE_STOPPED;
                                r_wptr[r_idx]   <= '0;
                                r_rptr[r_idx]   <= '0;
                                r_fill[r_idx]   <= '0;
                                r_played[r_idx] <= '0;
                                if (r_func == msarm_pkg::FUNC_OPEN) begin
                                    r_open[r_idx] <= 1'b1;
                                    r_gain[r_idx] <= msarm_pkg::FULL_SCALE;
                                end else if (r_func == msarm_pkg::FUNC_CLOSE) begin
                                    r_open[r_idx] <= 1'b0;
                                end
                            end
                        endcase
                    end
                end
                S_RD: begin
                    r_elig  <= r_open[r_idx] && (r_mode[r_idx] == msarm_pkg::MODE_PLAYING)
                               && (r_fill[r_idx] != '0);
                    r_state <= S_MUL;
                end
                S_MUL: begin
                    if (r_elig) begin
                        r_prod <= PROD_W'($signed(r_mem_q) * $signed({1'b0, r_gain[r_idx]}));
                        r_rptr[r_idx]   <= (r_rptr[r_idx] == PTR_W'(RING_SAMPLES - 1))
                                           ? '0 : r_rptr[r_idx] + 1'b1;
                        r_fill[r_idx]   <= r_fill[r_idx] - 1'b1;
                        r_played[r_idx] <= r_played[r_idx] + 1'b1;
                    end else begin
                        r_prod <= '0;
                    end
                    r_state <= S_REC;
                end
                S_REC: begin
                    r_neg   <= r_prod[PROD_W-1];
                    r_rec   <= msarm_pkg::ABS_W'(prod_abs) * msarm_pkg::RECIP_M;
                    r_state <= r_mphase ? S_MFIN : S_ACC;
                end
                S_ACC: begin
                    r_sum <= r_sum + SUM_W'(quo_s);
                    if (last_src) begin
                        r_state <= S_MMUL;
                    end else begin
                        r_idx   <= r_idx + 1'b1;
                        r_state <= S_RD;
                    end
                end
                S_MMUL: begin
                    r_prod   <= PROD_W'(r_sum * $signed({1'b0, r_master}));
                    r_mphase <= 1'b1;
                    r_state  <= S_REC;
                end
                S_MFIN: begin
                    if (quo_s > msarm_pkg::SAT_HI) begin
                        r_mix <= 16'h7FFF;
                    end else if (quo_s < msarm_pkg::SAT_LO) begin
                        r_mix <= 16'h8000;
                    end else begin
                        r_mix <= quo_s[15:0];
                    end
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    if (!r_m_valid || m_axis_tready) begin
                        r_m_valid <= 1'b1;
                        r_m_user  <= r_status;
                        if (r_func == msarm_pkg::FUNC_MIX) begin
                            r_m_data <= {56'd0, r_mix};
                        end else if (r_blank) begin
                            r_m_data <= {53'd0,
                                         (r_func == msarm_pkg::FUNC_OPEN) ? 3'd0 : r_sel,
                                         16'd0};
                        end else begin
                            r_m_data <= {2'd0, r_open[r_idx], r_gain[r_idx], r_played[r_idx],
                                         free17[10:0],
                                         (r_func == msarm_pkg::FUNC_OPEN) ? 3'(r_idx) : r_sel,
                                         16'd0};
                        end
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule
`default_nettype wire

@@ tb/multi_source_audio_ring_mixer_test.sv @@
// Self-checking ring mixer testbench: directed table, saturation, overflow, random ops.
`timescale 1ns / 1ps
`default_nettype none
module multi_source_audio_ring_mixer_test;

    typedef struct packed {
        msarm_pkg::t_func func;
        logic [2:0] sel;
        logic [15:0] smp;
        logic [6:0] gain;
    } t_op;

    typedef struct packed {
        logic [1:0]  status;
        logic [15:0] mixed;
        logic [2:0]  idx;
        logic [10:0] free;
        logic [31:0] played;
        logic [6:0]  vol;
        logic        active;
    } t_res;

    typedef struct {
        t_op  op;
        logic known;
        t_res res;
    } t_row;

    localparam int NSRC = 8;
    localparam int RING = 1024;
    localparam int LIMIT = 500000;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [6:0]  i_cfg_data = '0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [23:0] s_axis_tdata = '0;
    logic [5:0]  s_axis_tuser = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [71:0] m_axis_tdata;
    logic [1:0]  m_axis_tuser;

    multi_source_audio_ring_mixer u_top (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_valid(i_cfg_valid), .o_cfg_ready(o_cfg_ready), .i_cfg_data(i_cfg_data),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // mixer state mirror
    logic signed [15:0] ring_mem [NSRC][RING];
    int unsigned wr_ptr [NSRC];
    int unsigned rd_ptr [NSRC];
    int unsigned fill [NSRC];
    logic [31:0] played [NSRC];
    logic [6:0]  gain [NSRC];
    msarm_pkg::t_mode mode [NSRC];
    logic        is_open [NSRC];
    logic [6:0]  master;

    t_res expected_q [$];
    int   errors = 0;
    int   cycles = 0;
    int   stall_left = 0;
    bit   calm = 1'b0;
    bit   hold_long = 1'b0;
    bit   sender_done = 1'b0;

    function automatic void clear_ring(int s);
        wr_ptr[s] = 0;
        rd_ptr[s] = 0;
        fill[s] = 0;
        played[s] = '0;
    endfunction

    function automatic void reset_mirror();
        for (int s = 0; s < NSRC; s++) begin
            clear_ring(s);
            gain[s] = msarm_pkg::FULL_SCALE;
            mode[s] = msarm_pkg::MODE_STOPPED;
            is_open[s] = 1'b0;
        end
        master = msarm_pkg::MASTER_RESET;
    endfunction

    function automatic void fill_source(ref t_res r, input int s);
        r.idx = 3'(s);
        r.free = 11'(RING - fill[s]);
        r.played = played[s];
        r.vol = gain[s];
        r.active = is_open[s];
    endfunction

    function automatic t_res apply_op(t_op op);
        t_res r;
        int   sum;
        int   s;
        r = '0;
        s = op.sel;
        case (op.func)
            msarm_pkg::FUNC_MIX: begin
                sum = 0;
                for (int k = 0; k < NSRC; k++) begin
                    if (is_open[k] && mode[k] == msarm_pkg::MODE_PLAYING && fill[k] != 0) begin
                        sum += (int'(ring_mem[k][rd_ptr[k]]) * int'(gain[k])) / 100;
                        rd_ptr[k] = (rd_ptr[k] + 1) % RING;
                        fill[k]--;
                        played[k]++;
                    end
                end
                sum = (sum * int'(master)) / 100;
                if (sum > 32767) sum = 32767;
                if (sum < -32768) sum = -32768;
                r.mixed = 16'(sum);
                return r;
            end
            msarm_pkg::FUNC_OPEN: begin
                for (int k = 0; k < NSRC; k++) begin
                    if (!is_open[k]) begin
                        is_open[k] = 1'b1;
                        clear_ring(k);
                        gain[k] = msarm_pkg::FULL_SCALE;
                        mode[k] = msarm_pkg::MODE_STOPPED;
                        fill_source(r, k);
                        return r;
                    end
                end
                r.status = msarm_pkg::ST_INACTIVE;
                return r;
            end
            msarm_pkg::FUNC_WRITE: begin
                if (!is_open[s]) begin
                    r.status = msarm_pkg::ST_INACTIVE;
                end else if (fill[s] >= RING) begin
                    r.status = msarm_pkg::ST_FULL;
                end else begin
                    ring_mem[s][wr_ptr[s]] = op.smp;
                    wr_ptr[s] = (wr_ptr[s] + 1) % RING;
                    fill[s]++;
                end
            end
            msarm_pkg::FUNC_PLAY:   mode[s] = msarm_pkg::MODE_PLAYING;
            msarm_pkg::FUNC_PAUSE:  mode[s] = msarm_pkg::MODE_PAUSED;
            msarm_pkg::FUNC_STOP: begin
                mode[s] = msarm_pkg::MODE_STOPPED;
                clear_ring(s);
            end
            msarm_pkg::FUNC_VOLUME: begin
                gain[s] = op.gain > msarm_pkg::FULL_SCALE ? msarm_pkg::FULL_SCALE : op.gain;
            end
            default: begin
                is_open[s] = 1'b0;
                mode[s] = msarm_pkg::MODE_STOPPED;
                clear_ring(s);
            end
        endcase
        fill_source(r, s);
        return r;
    endfunction

    // receiver: stall bursts, long hold-off on request
    always @(negedge i_clk) begin
        if (hold_long) begin
            m_axis_tready <= 1'b0;
        end else if (calm) begin
            m_axis_tready <= 1'b1;
        end else if (stall_left > 0) begin
            m_axis_tready <= 1'b0;
            stall_left <= stall_left - 1;
        end else if ($urandom_range(0, 3) == 0) begin
            m_axis_tready <= 1'b0;
            stall_left <= $urandom_range(0, 3);
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        t_res got;
        t_res exp_r;
        cycles <= cycles + 1;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got = '{status: m_axis_tuser, mixed: m_axis_tdata[15:0],
                    idx: m_axis_tdata[18:16], free: m_axis_tdata[29:19],
                    played: m_axis_tdata[61:30], vol: m_axis_tdata[68:62],
                    active: m_axis_tdata[69]};
            if (expected_q.size() == 0) begin
                $error("unexpected result %h", got);
                errors++;
            end else begin
                exp_r = expected_q.pop_front();
                if (got.status !== exp_r.status) begin
                    $error("status exp %0d got %0d", exp_r.status, got.status); errors++;
                end
                if (got.mixed !== exp_r.mixed) begin
                    $error("mixed_sample exp %0d got %0d", $signed(exp_r.mixed),
                           $signed(got.mixed)); errors++;
                end
                if (got.idx !== exp_r.idx) begin
                    $error("source_index exp %0d got %0d", exp_r.idx, got.idx); errors++;
                end
                if (got.free !== exp_r.free) begin
                    $error("free_samples exp %0d got %0d", exp_r.free, got.free); errors++;
                end
                if (got.played !== exp_r.played) begin
                    $error("played_samples exp %0d got %0d", exp_r.played, got.played);
                    errors++;
                end
                if (got.vol !== exp_r.vol) begin
                    $error("current_volume exp %0d got %0d", exp_r.vol, got.vol); errors++;
                end
                if (got.active !== exp_r.active) begin
                    $error("source_active exp %0d got %0d", exp_r.active, got.active);
                    errors++;
                end
            end
        end
        if (cycles > LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    task automatic send_op(t_op op, logic known, t_res given);
        t_res pred;
        int   gap;
        gap = 0;
        if (!calm && $urandom_range(0, 3) == 0) gap = $urandom_range(1, 4);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_axis_tdata <= {1'b0, op.gain, op.smp};
        s_axis_tuser <= {op.sel, op.func};
        s_axis_tvalid <= 1'b1;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        pred = apply_op(op);
        if (known && pred !== given) begin
            $error("table row disagrees with predictor: exp %h pred %h", given, pred);
            errors++;
        end
        expected_q.push_back(pred);
        @(negedge i_clk);
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (expected_q.size() != 0) @(negedge i_clk);
        repeat (60) @(negedge i_clk);
    endtask

    task automatic write_master(logic [6:0] v);
        i_cfg_data <= v;
        i_cfg_valid <= 1'b1;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        master = v > msarm_pkg::FULL_SCALE ? msarm_pkg::FULL_SCALE : v;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    function automatic t_op mk(msarm_pkg::t_func f, int sel, int smp, int g);
        t_op o;
        o.func = f;
        o.sel = 3'(sel);
        o.smp = 16'(smp);
        o.gain = 7'(g);
        return o;
    endfunction

    function automatic t_op random_op();
        int r;
        r = $urandom_range(0, 99);
        if (r < 45) return mk(msarm_pkg::FUNC_WRITE, $urandom_range(0, 7), $urandom, $urandom);
        if (r < 70) return mk(msarm_pkg::FUNC_MIX, $urandom_range(0, 7), $urandom, $urandom);
        if (r < 78) return mk(msarm_pkg::FUNC_PLAY, $urandom_range(0, 7), $urandom, $urandom);
        if (r < 81) return mk(msarm_pkg::FUNC_PAUSE, $urandom_range(0, 7), $urandom, $urandom);
        if (r < 83) return mk(msarm_pkg::FUNC_STOP, $urandom_range(0, 7), $urandom, $urandom);
        if (r < 90) return mk(msarm_pkg::FUNC_VOLUME, $urandom_range(0, 7), $urandom, $urandom);
        if (r < 96) return mk(msarm_pkg::FUNC_OPEN, $urandom_range(0, 7), $urandom, $urandom);
        return mk(msarm_pkg::FUNC_CLOSE, $urandom_range(0, 7), $urandom, $urandom);
    endfunction

    t_row table_rows [$];

    initial begin
        t_res z;
        t_op  op;
        reset_mirror();
        repeat (4) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        z = '0;
        table_rows.push_back('{mk(msarm_pkg::FUNC_WRITE, 0, 0, 0), 1'b1,
                               '{msarm_pkg::ST_INACTIVE, 16'd0, 3'd0, 11'd1024, 32'd0,
                                 7'd100, 1'b0}});
        table_rows.push_back('{mk(msarm_pkg::FUNC_MIX, 7, 0, 0), 1'b1, z});
        for (int k = 0; k < NSRC; k++)
            table_rows.push_back('{mk(msarm_pkg::FUNC_OPEN, 7 - k, 0, 0), 1'b1,
                                   '{msarm_pkg::ST_OK, 16'd0, 3'(k), 11'd1024, 32'd0,
                                     7'd100, 1'b1}});
        table_rows.push_back('{mk(msarm_pkg::FUNC_OPEN, 0, 0, 0), 1'b1,
                               '{msarm_pkg::ST_INACTIVE, 16'd0, 3'd0, 11'd0, 32'd0,
                                 7'd0, 1'b0}});
        table_rows.push_back('{mk(msarm_pkg::FUNC_WRITE, 0, 32767, 0), 1'b0, z});
        table_rows.push_back('{mk(msarm_pkg::FUNC_WRITE, 1, -32768, 0), 1'b0, z});
        table_rows.push_back('{mk(msarm_pkg::FUNC_WRITE, 2, 32767, 0), 1'b0, z});
        table_rows.push_back('{mk(msarm_pkg::FUNC_VOLUME, 1, 0, 127), 1'b0, z});
        table_rows.push_back('{mk(msarm_pkg::FUNC_VOLUME, 2, 0, 37), 1'b0, z});
        table_rows.push_back('{mk(msarm_pkg::FUNC_PLAY, 0, 0, 0), 1'b0, z});
        table_rows.push_back('{mk(msarm_pkg::FUNC_PLAY, 1, 0, 0), 1'b0, z});
        table_rows.push_back('{mk(msarm_pkg::FUNC_PLAY, 2, 0, 0), 1'b0, z});
        table_rows.push_back('{mk(msarm_pkg::FUNC_MIX, 0, 0, 0), 1'b0, z});
        table_rows.push_back('{mk(msarm_pkg::FUNC_PAUSE, 2, 0, 0), 1'b0, z});
        table_rows.push_back('{mk(msarm_pkg::FUNC_STOP, 1, 0, 0), 1'b0, z});
        table_rows.push_back('{mk(msarm_pkg::FUNC_CLOSE, 3, 0, 0), 1'b0, z});
        table_rows.push_back('{mk(msarm_pkg::FUNC_VOLUME, 3, 0, 0), 1'b0, z});

        foreach (table_rows[i]) send_op(table_rows[i].op, table_rows[i].known,
                                        table_rows[i].res);
        drain();

        // saturate: full-scale writes and play on every source, master full scale
        write_master(7'd127);
        for (int k = 0; k < NSRC; k++) begin
            send_op(mk(msarm_pkg::FUNC_WRITE, k, 32767, 0), 1'b0, z);
            send_op(mk(msarm_pkg::FUNC_PLAY, k, 0, 0), 1'b0, z);
        end
        send_op(mk(msarm_pkg::FUNC_MIX, 0, 0, 0), 1'b0, z);
        for (int k = 0; k < NSRC; k++)
            send_op(mk(msarm_pkg::FUNC_WRITE, k, -32768, 0), 1'b0, z);
        send_op(mk(msarm_pkg::FUNC_MIX, 0, 0, 0), 1'b0, z);
        drain();

        // fill one ring to overflow, with a long receiver hold-off
        fork
            begin
                @(negedge i_clk);
                hold_long <= 1'b1;
                repeat (300) @(negedge i_clk);
                hold_long <= 1'b0;
            end
            for (int n = 0; n < RING + 3; n++)
                send_op(mk(msarm_pkg::FUNC_WRITE, 5, $urandom, 0), 1'b0, z);
        join
        drain();
        write_master(7'd0);

        for (int ph = 0; ph < 4; ph++) begin
            for (int n = 0; n < 230; n++) begin
                if (ph == 3 && n == 130) calm = 1'b1;
                op = random_op();
                send_op(op, 1'b0, z);
            end
            drain();
            case (ph)
                0: write_master(7'd100);
                1: write_master(7'($urandom_range(1, 99)));
                default: write_master(7'd80);
            endcase
        end
        drain();
        if (errors == 0) $display("tb: success");
        else $display("tb: failure");
        $finish;
    end
endmodule
`default_nettype wire

@@ filelist.f @@
hdl/msarm_pkg.sv
hdl/multi_source_audio_ring_mixer.sv
tb/multi_source_audio_ring_mixer_test.sv
